### src/kfc_pkg.sv
// ----------------------------------------------------------------------------
// kfc_pkg: shared types and constants of the k-mer frequency counter
// Holds the item and result structs, the item kind codes, the register
// width, and the command and status structs between controller and datapath.
// ----------------------------------------------------------------------------
package kfc_pkg;

    // Built defaults for the top-level parameters.
    localparam int DEF_MAX_K      = 8;
    localparam int DEF_COUNT_BITS = 32;

    // Field widths fixed by the interface.
    localparam int KIND_BITS  = 2;
    localparam int BASE_BITS  = 2;
    localparam int QID_BITS   = 16;
    localparam int VALUE_BITS = 32;
    localparam int KLEN_BITS  = 4;

    localparam logic [KLEN_BITS-1:0] KLEN_RESET = 4'd8;

    // Item kind codes.
    localparam logic [KIND_BITS-1:0] KIND_BASE  = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_END   = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_QUERY = 2'd2;

    typedef struct packed {
        logic [KIND_BITS-1:0] kind;
        logic [BASE_BITS-1:0] base;
        logic [QID_BITS-1:0]  query_id;
    } item_t;

    typedef struct packed {
        logic [QID_BITS-1:0]   count_id;
        logic [VALUE_BITS-1:0] count_value;
    } result_t;

    // Controller to datapath.
    typedef struct packed {
        logic take;      // an input item transfers this cycle
        logic clear_wr;  // write zero at the clearing address
        logic rd_b;      // read the reverse-complement counter
        logic wr_a;      // write back the forward counter
        logic wr_b;      // write back the reverse-complement counter
        logic out_load;  // load the result register
    } ctrl_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic [KIND_BITS-1:0] kind;  // kind of the offered item
        logic                 hit;   // the offered base completes a k-mer
        logic                 clear_last;
    } dp_status_t;

endpackage

### src/kfc_datapath.sv
// ----------------------------------------------------------------------------
// kfc_datapath: base window, k-mer id logic and count memory
// Shifts bases into the window, forms the k-mer id and its reverse
// complement, and does the saturating read-modify-write updates of the
// count memory with a one-entry bypass for a read that meets a write.
// ----------------------------------------------------------------------------
module kfc_datapath #(
    parameter int MAX_K      = kfc_pkg::DEF_MAX_K,
    parameter int COUNT_BITS = kfc_pkg::DEF_COUNT_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  kfc_pkg::item_t                   in_data,
    input  logic                             cfg_valid,
    input  logic [kfc_pkg::KLEN_BITS-1:0]    cfg_data,
    input  kfc_pkg::ctrl_cmd_t               cmd,
    output kfc_pkg::dp_status_t              sts,
    output kfc_pkg::result_t                 out_data
);
    import kfc_pkg::*;

    localparam int ID_BITS = 2 * MAX_K;
    localparam int DEPTH   = 2 ** ID_BITS;
    localparam int CNT_W   = $clog2(MAX_K + 1);
    localparam logic [KLEN_BITS-1:0] K_MAX = KLEN_BITS'(MAX_K);
    localparam logic [KLEN_BITS-1:0] K_ONE = KLEN_BITS'(1);
    localparam logic [CNT_W-1:0]     BASES_FULL = CNT_W'(MAX_K);

    logic [KLEN_BITS-1:0]  klen_reg, klen_next, k_eff;
    logic [ID_BITS-1:0]    window_reg, window_next, win_shift;
    logic [CNT_W-1:0]      bases_reg, bases_next, bases_inc;
    logic [ID_BITS-1:0]    clear_cnt_reg, clear_cnt_next;
    logic [ID_BITS-1:0]    kmask, id_a, rc_full, id_b, q_idx;
    logic [ID_BITS-1:0]    id_a_reg, id_b_reg;
    logic [QID_BITS-1:0]   qid_reg;
    logic                  hit;

    logic [COUNT_BITS-1:0] count_mem [DEPTH];
    logic [COUNT_BITS-1:0] rd_q_reg, fwd_data_reg, rd_val, inc_val, wdata;
    logic                  fwd_hit_reg;
    logic [ID_BITS-1:0]    raddr, waddr;
    logic                  re, we;
    result_t               out_data_reg;

    // Effective k-mer length: zero acts as one, too large acts as MAX_K.
    always_comb
    begin
        if (klen_reg == '0)
            k_eff = K_ONE;
        else if (klen_reg > K_MAX)
            k_eff = K_MAX;
        else
            k_eff = klen_reg;
    end

    assign win_shift = (window_reg << 2) | ID_BITS'(in_data.base);
    assign bases_inc = (bases_reg == BASES_FULL) ? bases_reg : bases_reg + 1'b1;
    assign hit       = KLEN_BITS'(bases_inc) >= k_eff;
    assign kmask     = ~({ID_BITS{1'b1}} << {k_eff, 1'b0});
    assign id_a      = win_shift & kmask;

    // Reverse complement over the full window, then aligned to k digits.
    always_comb
    begin
        rc_full = '0;
        for (int j = 0; j < MAX_K; j++)
        begin
            rc_full[2*j +: 2] = ~id_a[2*(MAX_K-1-j) +: 2];
        end
    end

    assign id_b  = rc_full >> {K_MAX - k_eff, 1'b0};
    assign q_idx = ID_BITS'(in_data.query_id);

    always_comb
    begin
        window_next = window_reg;
        bases_next  = bases_reg;
        if (cmd.take)
        begin
            case (in_data.kind)
                KIND_BASE:
                begin
                    window_next = win_shift;
                    bases_next  = bases_inc;
                end
                KIND_END:
                begin
                    window_next = '0;
                    bases_next  = '0;
                end
                default:
                begin
                    window_next = window_reg;
                    bases_next  = bases_reg;
                end
            endcase
        end
    end

    assign klen_next      = cfg_valid ? cfg_data : klen_reg;
    assign clear_cnt_next = cmd.clear_wr ? clear_cnt_reg + 1'b1 : clear_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            klen_reg      <= KLEN_RESET;
            window_reg    <= '0;
            bases_reg     <= '0;
            clear_cnt_reg <= '0;
        end
        else
        begin
            klen_reg      <= klen_next;
            window_reg    <= window_next;
            bases_reg     <= bases_next;
            clear_cnt_reg <= clear_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            id_a_reg <= id_a;
            id_b_reg <= id_b;
            qid_reg  <= in_data.query_id;
        end
        if (cmd.out_load)
        begin
            out_data_reg.count_id    <= qid_reg;
            out_data_reg.count_value <= VALUE_BITS'(rd_val);
        end
    end

    // Count memory: one write and one registered read per cycle.
    assign re    = cmd.take || cmd.rd_b;
    assign raddr = cmd.rd_b ? id_b_reg : ((in_data.kind == KIND_QUERY) ? q_idx : id_a);
    assign we    = cmd.clear_wr || cmd.wr_a || cmd.wr_b;
    assign waddr = cmd.clear_wr ? clear_cnt_reg : (cmd.wr_a ? id_a_reg : id_b_reg);

    assign rd_val  = fwd_hit_reg ? fwd_data_reg : rd_q_reg;
    assign inc_val = (&rd_val) ? rd_val : rd_val + 1'b1;
    assign wdata   = cmd.clear_wr ? '0 : inc_val;

    always_ff @(posedge clk)
    begin
        if (we)
            count_mem[waddr] <= wdata;
        if (re)
        begin
            rd_q_reg     <= count_mem[raddr];
            fwd_hit_reg  <= we && (waddr == raddr);
            fwd_data_reg <= wdata;
        end
    end

    assign sts.kind       = in_data.kind;
    assign sts.hit        = hit;
    assign sts.clear_last = &clear_cnt_reg;
    assign out_data       = out_data_reg;

endmodule

### src/kfc_ctrl.sv
// ----------------------------------------------------------------------------
// kfc_ctrl: sequencing state machine of the k-mer frequency counter
// Runs the clearing pass, steps each counted base through its two counter
// updates, and owns the result valid flag.
// ----------------------------------------------------------------------------
module kfc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  kfc_pkg::dp_status_t  sts,
    output kfc_pkg::ctrl_cmd_t   cmd
);
    import kfc_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPD_A,
        ST_UPD_B,
        ST_QUERY
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   take;

    assign in_ready = (state_reg == ST_IDLE) || (state_reg == ST_UPD_B);
    assign take     = in_valid && in_ready;

    always_comb
    begin
        cmd.take     = take;
        cmd.clear_wr = (state_reg == ST_CLEAR);
        cmd.rd_b     = (state_reg == ST_UPD_A);
        cmd.wr_a     = (state_reg == ST_UPD_A);
        cmd.wr_b     = (state_reg == ST_UPD_B);
        cmd.out_load = (state_reg == ST_QUERY) && (!out_valid_reg || out_ready);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (sts.clear_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE, ST_UPD_B:
            begin
                state_next = ST_IDLE;
                if (take)
                begin
                    unique case (sts.kind)
                        KIND_BASE:  state_next = sts.hit ? ST_UPD_A : ST_IDLE;
                        KIND_QUERY: state_next = ST_QUERY;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_UPD_A:
            begin
                state_next = ST_UPD_B;
            end
            ST_QUERY:
            begin
                if (cmd.out_load)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_upd_a_after_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPD_A) |-> $past(take && sts.kind == KIND_BASE && sts.hit))
        else $error("forward update without a counted base");

    a_wr_b_after_wr_a: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_b |-> $past(cmd.wr_a))
        else $error("reverse-complement write without preceding forward write");

    a_result_from_query: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_QUERY))
        else $error("result raised outside a query");

    a_clear_runs_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR && !sts.clear_last) |=> (state_reg == ST_CLEAR))
        else $error("clearing pass left early");
`endif

endmodule

### src/kmer_frequency_counter.sv
// ----------------------------------------------------------------------------
// kmer_frequency_counter: k-mer counting histogram over a stream of DNA bases
// Top level joining the sequencing controller and the counting datapath.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass that writes zero to every one of
// the 4^MAX_K counters, one per cycle (65536 counters at the default MAX_K of 8);
// in_ready stays low until it ends, while configuration writes are taken at
// any time. Bases (kind 0) are shifted into a window of the last MAX_K bases;
// once the current read holds kmer_length bases, each base increments the
// saturating count of its k-mer id and of the id's reverse complement, so a
// palindromic k-mer is counted twice. An end-of-read item (kind 1) empties
// the window. A query (kind 2) returns the id and the count stored there.
// Kind 3 is ignored. A counted base passes through ST_UPD_A and ST_UPD_B: the
// count memory has one write port, and the two read-modify-write updates each
// need a write; the first counter is read in the transfer cycle, the next item
// can transfer in the cycle that writes the second counter, and a bypass
// covers a read that meets a write to the same counter. Bases that complete
// no k-mer, end-of-read items and ignored items leave the block in ST_IDLE.
// A query waits in ST_QUERY only while an earlier result has not been
// taken. kmer_length (1 to MAX_K; 0 acts as 1, larger values as MAX_K) is
// to be written only while the block is idle; cfg_ready is always high.
// ----------------------------------------------------------------------------
module kmer_frequency_counter #(
    parameter int MAX_K      = kfc_pkg::DEF_MAX_K,
    parameter int COUNT_BITS = kfc_pkg::DEF_COUNT_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  kfc_pkg::item_t                 in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output kfc_pkg::result_t               out_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [kfc_pkg::KLEN_BITS-1:0]  cfg_data
);
    import kfc_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t sts;

    // The length register can take a transfer in every cycle.
    assign cfg_ready = 1'b1;

    kfc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    kfc_datapath #(
        .MAX_K      (MAX_K),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_data  (out_data)
    );

endmodule
